// ----- sv/qte_pkg.sv -----
`default_nettype none
package qte_pkg;

	// Angle accumulator: degrees with 20 fraction bits, signed.
	localparam int ANG_FRAC  = 20;
	localparam int ANG_W     = 31;
	localparam int TABLE_LEN = 24;
	// CORDIC datapath width after normalization to at least 2^40.
	localparam int CW        = 45;
	// Width of the atan2 operands coming from the sums.
	localparam int OPW       = 34;

	localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 << ANG_FRAC);

	localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121,
		31'sd3750059,  31'sd1876857,  31'sd938658,   31'sd469357,
		31'sd234682,   31'sd117342,   31'sd58671,    31'sd29335,
		31'sd14668,    31'sd7334,     31'sd3667,     31'sd1833,
		31'sd917,      31'sd458,      31'sd229,      31'sd115,
		31'sd57,       31'sd29,       31'sd14,       31'sd7
	};

	localparam logic signed [15:0] PITCH_LIM = 16'sd11520;

	typedef struct packed {
		logic zero;
		logic clamp;
		logic sp_zero;
		logic sp_neg;
	} qte_flags_t;

endpackage
`default_nettype wire

// ----- sv/quaternion_to_euler_angles_core.sv -----
`default_nettype none
// Channel | Dir | Bits | Contents
// s_axis  | in  | 64   | tdata: quat_x, quat_y, quat_z, quat_w
// m_axis  | out | 48   | tdata: roll_deg, pitch_deg, yaw_deg; tuser: pitch_clamped
//
// Fully pipelined: one request per cycle unless m_tready back-pressure stalls the pipeline.
// The depth is set by the pitch path: a 32-stage square root followed by the
// CORDIC atan2 pipeline of ANGLE_ITERATIONS + 3 stages.
// Reset clears only the valid bits. Each stage holds while the stage after it
// is full and stalled, so bubbles close up and nothing is dropped or repeated.
module quaternion_to_euler_angles_core #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // roll_deg, pitch_deg, yaw_deg, zero pad
	output logic      [0:0]  m_tuser    // pitch_clamped
);

	localparam int LAT    = ANGLE_ITERATIONS + 3;
	localparam int SQ_END = 38;
	localparam int P_END  = SQ_END + LAT;
	localparam int NS     = P_END + 1;
	localparam int OPW    = qte_pkg::OPW;

	logic [NS:1]   v_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = m_tready;
		for (int k = NS; k >= 1; k--) en[k] = !v_q[k] || en[k+1];
	end

	assign s_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= s_tvalid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// Stage 1: all ten products.
	logic signed [15:0] qx, qy, qz, qw;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1, wx_s1, yz_s1, wz_s1, xy_s1, wy_s1, zx_s1;

	assign qx = s_tdata[15:0];
	assign qy = s_tdata[31:16];
	assign qz = s_tdata[47:32];
	assign qw = s_tdata[63:48];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			ww_s1 <= qw * qw;
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
		end
	end

	// Stage 2: squared length and the atan2 / asin arguments.
	logic [32:0]           n_s2;
	logic signed [OPW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, sp_s2;
	logic signed [34:0]    n35, sr35, cr35, sy35, cy35, sp35;

	always_comb begin
		n35  = 35'(xx_s1) + 35'(yy_s1) + 35'(zz_s1) + 35'(ww_s1);
		sr35 = (35'(wx_s1) + 35'(yz_s1)) <<< 1;
		cr35 = n35 - ((35'(xx_s1) + 35'(yy_s1)) <<< 1);
		sy35 = (35'(wz_s1) + 35'(xy_s1)) <<< 1;
		cy35 = n35 - ((35'(yy_s1) + 35'(zz_s1)) <<< 1);
		sp35 = (35'(wy_s1) - 35'(zx_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			n_s2  <= n35[32:0];
			sr_s2 <= sr35[OPW-1:0];
			cr_s2 <= cr35[OPW-1:0];
			sy_s2 <= sy35[OPW-1:0];
			cy_s2 <= cy35[OPW-1:0];
			sp_s2 <= sp35[OPW-1:0];
		end
	end

	// Stage 3: special-case flags and the shift that lifts n to 2^31.
	logic [32:0]         n_s3, msp_s3, msp_c;
	logic [4:0]          k_s3, kc;
	qte_pkg::qte_flags_t fl_d [3:P_END];

	always_comb begin
		msp_c = sp_s2[OPW-1] ? 33'(-sp_s2) : 33'(sp_s2);
		kc    = 5'd0;
		if (n_s2[32:31] == 2'b00) begin
			for (int i = 0; i < 31; i++) begin
				if (n_s2[i]) kc = 5'(31 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			n_s3            <= n_s2;
			msp_s3          <= msp_c;
			k_s3            <= kc;
			fl_d[3].zero    <= (n_s2 == '0);
			fl_d[3].clamp   <= (msp_c >= n_s2);
			fl_d[3].sp_zero <= (sp_s2 == '0);
			fl_d[3].sp_neg  <= sp_s2[OPW-1];
		end
		for (int j = 4; j <= P_END; j++) begin
			if (en[j]) fl_d[j] <= fl_d[j-1];
		end
	end

	// Stage 4: apply the shift; only used when |sp| < n, so both fit 32 bits.
	logic [31:0]           n_s4, us_s4;
	logic [32:0]           nsh, ush;
	logic signed [OPW-1:0] sp_d [4:SQ_END];

	always_comb begin
		nsh = n_s3 << k_s3;
		ush = msp_s3 << k_s3;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			n_s4    <= nsh[31:0];
			us_s4   <= ush[31:0];
			sp_d[4] <= fl_d[3].sp_neg ? -$signed({2'b00, ush[31:0]}) : $signed({2'b00, ush[31:0]});
		end
		for (int j = 5; j <= SQ_END; j++) begin
			if (en[j]) sp_d[j] <= sp_d[j-1];
		end
	end

	// Stages 5 and 6: n^2 - sp^2 for the cosine of pitch.
	logic [63:0] nn_s5, ss_s5, c2_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			nn_s5 <= n_s4 * n_s4;
			ss_s5 <= us_s4 * us_s4;
		end
		if (en[6]) c2_s6 <= nn_s5 - ss_s5;
	end

	logic [31:0] cp_root;

	qte_isqrt u_sqrt (
		.clk  (clk),
		.en   (en[SQ_END:7]),
		.v_in (c2_s6),
		.root (cp_root)
	);

	logic signed [15:0] roll_a, yaw_a;
	logic signed [14:0] pitch_a;

	qte_atan2 #(.ITER(ANGLE_ITERATIONS), .OUT_W(16), .LIM(23040)) u_roll (
		.clk     (clk),
		.en      (en[LAT+2:3]),
		.a       (cr_s2),
		.b       (sr_s2),
		.ang_out (roll_a)
	);

	qte_atan2 #(.ITER(ANGLE_ITERATIONS), .OUT_W(16), .LIM(23040)) u_yaw (
		.clk     (clk),
		.en      (en[LAT+2:3]),
		.a       (cy_s2),
		.b       (sy_s2),
		.ang_out (yaw_a)
	);

	qte_atan2 #(.ITER(ANGLE_ITERATIONS), .OUT_W(15), .LIM(11520)) u_pitch (
		.clk     (clk),
		.en      (en[P_END:SQ_END+1]),
		.a       ($signed({2'b00, cp_root})),
		.b       (sp_d[SQ_END]),
		.ang_out (pitch_a)
	);

	// Roll and yaw finish early and wait for pitch.
	logic signed [15:0] roll_d [LAT+3:P_END];
	logic signed [15:0] yaw_d  [LAT+3:P_END];

	always_ff @(posedge clk) begin
		if (en[LAT+3]) begin
			roll_d[LAT+3] <= roll_a;
			yaw_d[LAT+3]  <= yaw_a;
		end
		for (int j = LAT + 4; j <= P_END; j++) begin
			if (en[j]) begin
				roll_d[j] <= roll_d[j-1];
				yaw_d[j]  <= yaw_d[j-1];
			end
		end
	end

	// Output register: apply the zero, clamped and zero-sine cases.
	logic signed [15:0] roll_q, yaw_q;
	logic signed [14:0] pitch_q;
	logic               clamp_q;

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (fl_d[P_END].zero) begin
				roll_q  <= '0;
				yaw_q   <= '0;
				pitch_q <= '0;
				clamp_q <= 1'b0;
			end else begin
				roll_q  <= roll_d[P_END];
				yaw_q   <= yaw_d[P_END];
				clamp_q <= fl_d[P_END].clamp;
				priority if (fl_d[P_END].clamp)
					pitch_q <= fl_d[P_END].sp_neg ? -qte_pkg::PITCH_LIM[14:0]
					                              : qte_pkg::PITCH_LIM[14:0];
				else if (fl_d[P_END].sp_zero)
					pitch_q <= '0;
				else
					pitch_q <= pitch_a;
			end
		end
	end

	assign m_tvalid   = v_q[NS];
	assign m_tdata    = {1'b0, yaw_q, pitch_q, roll_q};
	assign m_tuser[0] = clamp_q;

endmodule
`default_nettype wire

// ----- sv/qte_isqrt.sv -----
`default_nettype none
module qte_isqrt (
	input  wire logic        clk,
	input  wire logic [31:0] en,
	input  wire logic [63:0] v_in,
	output logic      [31:0] root
);

	logic [63:0] rem_s [32];
	logic [63:0] res_s [32];

	// One result bit per stage, starting at the top pair of bits.
	for (genvar i = 0; i < 32; i++) begin : g_step
		localparam logic [63:0] BITC = 64'(1) << (62 - 2 * i);
		logic [63:0] rem_p, res_p, trial;
		always_comb begin
			rem_p = (i == 0) ? v_in : rem_s[(i == 0) ? 0 : i - 1];
			res_p = (i == 0) ? 64'd0 : res_s[(i == 0) ? 0 : i - 1];
			trial = res_p + BITC;
		end
		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (rem_p >= trial) begin
					rem_s[i] <= rem_p - trial;
					res_s[i] <= (res_p >> 1) + BITC;
				end else begin
					rem_s[i] <= rem_p;
					res_s[i] <= res_p >> 1;
				end
			end
		end
	end

	assign root = res_s[31][31:0];

endmodule
`default_nettype wire

// ----- sv/qte_atan2.sv -----
`default_nettype none
module qte_atan2 #(
	parameter int ITER  = 16,
	parameter int OUT_W = 16,
	parameter int LIM   = 23040
) (
	input  wire logic                          clk,
	input  wire logic [ITER+2:0]               en,
	input  wire logic signed [qte_pkg::OPW-1:0] a,
	input  wire logic signed [qte_pkg::OPW-1:0] b,
	output logic signed [OUT_W-1:0]            ang_out
);

	localparam int OPW = qte_pkg::OPW;
	localparam int CW  = qte_pkg::CW;
	localparam int AW  = qte_pkg::ANG_W;
	localparam int SH  = qte_pkg::ANG_FRAC - 7;

	// Stage 1: find the left shift that brings the larger magnitude to 2^40.
	logic signed [OPW-1:0] a_s1, b_s1;
	logic [5:0]            k_s1;
	logic                  zero_s1;
	logic [OPW-1:0]        ma, mb, mx;
	logic [5:0]            kc;

	always_comb begin
		ma = a[OPW-1] ? OPW'(-a) : OPW'(a);
		mb = b[OPW-1] ? OPW'(-b) : OPW'(b);
		mx = (ma > mb) ? ma : mb;
		kc = 6'd0;
		for (int i = 0; i < OPW; i++) begin
			if (mx[i]) kc = 6'(40 - i);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1    <= a;
			b_s1    <= b;
			k_s1    <= kc;
			zero_s1 <= (mx == '0);
		end
	end

	// Stage 2: scale, then fold the left half plane onto the right.
	logic signed [CW-1:0] xr [ITER+1];
	logic signed [CW-1:0] yr [ITER+1];
	logic signed [AW-1:0] zr [ITER+1];
	logic                 zf [ITER+1];
	logic signed [CW-1:0] as_c, bs_c;

	always_comb begin
		as_c = CW'(a_s1) <<< k_s1;
		bs_c = CW'(b_s1) <<< k_s1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			zf[0] <= zero_s1;
			if (as_c < 0) begin
				xr[0] <= -as_c;
				yr[0] <= -bs_c;
				zr[0] <= (bs_c >= 0) ? qte_pkg::DEG180 : -qte_pkg::DEG180;
			end else begin
				xr[0] <= as_c;
				yr[0] <= bs_c;
				zr[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en[2+i]) begin
				zf[i+1] <= zf[i];
				if (yr[i] > 0) begin
					xr[i+1] <= xr[i] + (yr[i] >>> i);
					yr[i+1] <= yr[i] - (xr[i] >>> i);
					zr[i+1] <= zr[i] + qte_pkg::ATAN_TAB[i];
				end else begin
					xr[i+1] <= xr[i] - (yr[i] >>> i);
					yr[i+1] <= yr[i] + (xr[i] >>> i);
					zr[i+1] <= zr[i] - qte_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	// Last stage: round halves away from zero to 1/128 degree and saturate.
	logic [AW-1:0]        magv, rnd;
	logic signed [AW-1:0] res;

	always_comb begin
		magv = zr[ITER][AW-1] ? AW'(-zr[ITER]) : AW'(zr[ITER]);
		rnd  = (magv + AW'(1 << (SH - 1))) >> SH;
		if (rnd > AW'(LIM)) rnd = AW'(LIM);
		res = zr[ITER][AW-1] ? -$signed(rnd) : $signed(rnd);
		if (zf[ITER]) res = '0;
	end

	always_ff @(posedge clk) begin
		if (en[ITER+2]) ang_out <= res[OUT_W-1:0];
	end

endmodule
`default_nettype wire
